[design/cpd_pkg.sv]
// Package for the channel packet deframer: constants, codes and shared types.
`default_nettype none

package cpd_pkg;

    // Packet geometry
    localparam int HEADER_WORDS = 6;
    localparam int MAX_SAMPLES  = 1024;

    // Offset within a packet (holds any 16-bit length plus one)
    localparam int OFF_W = 17;
    typedef logic [OFF_W-1:0] offset_t;

    // Header word positions
    localparam offset_t OFF_START    = OFF_W'(0);
    localparam offset_t OFF_LENGTH   = OFF_W'(1);
    localparam offset_t OFF_CHAN     = OFF_W'(3);
    localparam offset_t OFF_COUNT_HI = OFF_W'(4);
    localparam offset_t OFF_COUNT_LO = OFF_W'(5);
    localparam offset_t OFF_PAYLOAD  = OFF_W'(HEADER_WORDS);
    localparam offset_t OFF_MIN_END  = OFF_W'(HEADER_WORDS - 1);
    localparam offset_t SAMPLE_LIMIT = OFF_W'(MAX_SAMPLES);

    // Field widths of a result
    localparam int SAMPLE_W = 32;
    localparam int CHAN_W   = 5;
    localparam int CHIPA_W  = 4;
    localparam int INDEX_W  = 10;
    localparam int PKT_W    = 16;
    localparam int COUNT_W  = 20;

    localparam logic [CHIPA_W-1:0] CHIP_LIMIT = CHIPA_W'(2);
    localparam logic [PKT_W-1:0]   PKT_MAX    = '1;

    // Result kinds
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Buffer status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_BAD_CHIP = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // One result item
    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic                chip;
        logic [CHAN_W-1:0]   chan;
        logic [INDEX_W-1:0]  sample_index;
        status_t             status;
        logic [PKT_W-1:0]    packets_seen;
        logic [COUNT_W-1:0]  crossing_count;
        logic                end_mark;
    } result_t;

    // Results produced by one accepted word
    typedef struct packed {
        logic payload;
        logic summary;
    } push_t;

    // Output tdata: fields after kind and before end_mark, padded to bytes
    localparam int OUT_FIELDS_W = SAMPLE_W + 1 + CHAN_W + INDEX_W + 2 + PKT_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

[design/cpd_parse.sv]
// Header parsing, packet tracking and result building for the deframer.
`default_nettype none

module cpd_parse (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [31:0]          word,
    input  wire logic                 last_word,
    output cpd_pkg::push_t            push,
    output cpd_pkg::result_t          pay,
    output cpd_pkg::result_t          sum
);

    cpd_pkg::offset_t                   off_reg,     off_upd,     off_next;
    logic [15:0]                        len_reg,     len_upd,     len_next;
    logic [cpd_pkg::CHIPA_W-1:0]        chip_reg,    chip_upd,    chip_next;
    logic [cpd_pkg::CHAN_W-1:0]         chan_reg,    chan_upd,    chan_next;
    logic [15:0]                        cnt_hi_reg,  cnt_hi_upd,  cnt_hi_next;
    logic [cpd_pkg::COUNT_W-1:0]        ref_reg,     ref_upd,     ref_next;
    logic                               have_reg,    have_upd,    have_next;
    cpd_pkg::status_t                   err_reg,     err_upd,     err_next;
    logic [cpd_pkg::PKT_W-1:0]          pkt_reg,     pkt_upd,     pkt_next;

    logic                               fatal;
    logic                               pay_hit;
    cpd_pkg::offset_t                   idx;
    cpd_pkg::offset_t                   bound;
    logic [cpd_pkg::COUNT_W-1:0]        cnt;
    logic [cpd_pkg::COUNT_W-1:0]        xcount;

    assign fatal = (err_reg == cpd_pkg::ST_MISMATCH) || (err_reg == cpd_pkg::ST_BAD_CHIP);
    assign idx   = off_reg - cpd_pkg::OFF_PAYLOAD;
    assign cnt   = {cnt_hi_reg, word[3:0]};
    assign bound = ({1'b0, len_reg} < cpd_pkg::OFF_MIN_END) ? cpd_pkg::OFF_MIN_END
                                                             : {1'b0, len_reg};

    // Per-word state update
    always_comb
    begin
        off_upd    = off_reg;
        len_upd    = len_reg;
        chip_upd   = chip_reg;
        chan_upd   = chan_reg;
        cnt_hi_upd = cnt_hi_reg;
        ref_upd    = ref_reg;
        have_upd   = have_reg;
        err_upd    = err_reg;
        pkt_upd    = pkt_reg;
        pay_hit    = 1'b0;
        if (accept && !fatal)
        begin
            if (off_reg == cpd_pkg::OFF_START)
            begin
                if (pkt_reg != cpd_pkg::PKT_MAX)
                    pkt_upd = pkt_reg + 1'b1;
            end
            else if (off_reg == cpd_pkg::OFF_LENGTH)
            begin
                len_upd = word[15:0];
            end
            else if (off_reg == cpd_pkg::OFF_CHAN)
            begin
                chan_upd = word[4:0];
                chip_upd = word[8:5];
            end
            else if (off_reg == cpd_pkg::OFF_COUNT_HI)
            begin
                cnt_hi_upd = word[15:0];
            end
            else if (off_reg == cpd_pkg::OFF_COUNT_LO)
            begin
                // first packet sets the reference, later ones must match
                if (!have_reg)
                begin
                    ref_upd  = cnt;
                    have_upd = 1'b1;
                end
                else if (cnt != ref_reg)
                begin
                    err_upd = cpd_pkg::ST_MISMATCH;
                end
                if (err_upd != cpd_pkg::ST_MISMATCH && chip_reg >= cpd_pkg::CHIP_LIMIT)
                    err_upd = cpd_pkg::ST_BAD_CHIP;
            end
            else if (off_reg >= cpd_pkg::OFF_PAYLOAD && off_reg < {1'b0, len_reg})
            begin
                if (idx < cpd_pkg::SAMPLE_LIMIT)
                    pay_hit = 1'b1;
                else if (err_reg == cpd_pkg::ST_OK)
                    err_upd = cpd_pkg::ST_OVERFLOW;
            end

            // trailing word closes the packet
            if (off_reg >= cpd_pkg::OFF_LENGTH && off_reg >= bound)
                off_upd = cpd_pkg::OFF_START;
            else
                off_upd = off_reg + 1'b1;
        end
    end

    // End of buffer returns everything to reset values
    always_comb
    begin
        if (accept && last_word)
        begin
            off_next    = cpd_pkg::OFF_START;
            len_next    = '0;
            chip_next   = '0;
            chan_next   = '0;
            cnt_hi_next = '0;
            ref_next    = '0;
            have_next   = 1'b0;
            err_next    = cpd_pkg::ST_OK;
            pkt_next    = '0;
        end
        else
        begin
            off_next    = off_upd;
            len_next    = len_upd;
            chip_next   = chip_upd;
            chan_next   = chan_upd;
            cnt_hi_next = cnt_hi_upd;
            ref_next    = ref_upd;
            have_next   = have_upd;
            err_next    = err_upd;
            pkt_next    = pkt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= cpd_pkg::OFF_START;
            len_reg    <= '0;
            chip_reg   <= '0;
            chan_reg   <= '0;
            cnt_hi_reg <= '0;
            ref_reg    <= '0;
            have_reg   <= 1'b0;
            err_reg    <= cpd_pkg::ST_OK;
            pkt_reg    <= '0;
        end
        else
        begin
            off_reg    <= off_next;
            len_reg    <= len_next;
            chip_reg   <= chip_next;
            chan_reg   <= chan_next;
            cnt_hi_reg <= cnt_hi_next;
            ref_reg    <= ref_next;
            have_reg   <= have_next;
            err_reg    <= err_next;
            pkt_reg    <= pkt_next;
        end
    end

    // Result items built from the updated, pre-clear state
    assign xcount = have_upd ? ref_upd : '0;

    always_comb
    begin
        pay.kind           = cpd_pkg::KIND_SAMPLE;
        pay.sample         = word;
        pay.chip           = chip_upd[0];
        pay.chan           = chan_upd;
        pay.sample_index   = idx[cpd_pkg::INDEX_W-1:0];
        pay.status         = cpd_pkg::ST_OK;
        pay.packets_seen   = pkt_upd;
        pay.crossing_count = xcount;
        pay.end_mark       = 1'b0;

        sum.kind           = cpd_pkg::KIND_SUMMARY;
        sum.sample         = '0;
        sum.chip           = 1'b0;
        sum.chan           = '0;
        sum.sample_index   = '0;
        sum.status         = err_upd;
        sum.packets_seen   = pkt_upd;
        sum.crossing_count = xcount;
        sum.end_mark       = 1'b1;
    end

    assign push.payload = pay_hit;
    assign push.summary = accept && last_word;

    // Checks
    a_no_pay_after_fatal: assert property (@(posedge clk) disable iff (!rst_n)
        fatal |-> !push.payload)
        else $error("payload emitted after a fatal error");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_word) |=> (off_reg == cpd_pkg::OFF_START
                                   && err_reg == cpd_pkg::ST_OK && !have_reg))
        else $error("state not cleared after last word");

    a_pkt_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !fatal && !last_word && off_reg == cpd_pkg::OFF_START)
        |=> (pkt_reg != '0))
        else $error("packet start not counted");

endmodule

`default_nettype wire

[design/cpd_out_queue.sv]
// Two-entry result queue; each entry holds the results of one word.
`default_nettype none

module cpd_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cpd_pkg::push_t    push,
    input  wire cpd_pkg::result_t  pay,
    input  wire cpd_pkg::result_t  sum,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cpd_pkg::result_t       out_item
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             pay_v;
        logic             sum_v;
        cpd_pkg::result_t pay;
        cpd_pkg::result_t sum;
    } entry_t;

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               half_reg,   half_next;

    entry_t             head;
    entry_t             wr_entry;
    logic               wr_en;
    logic               show_pay;
    logic               fire;
    logic               pop;

    assign wr_en    = push.payload || push.summary;
    assign wr_entry = '{pay_v: push.payload, sum_v: push.summary, pay: pay, sum: sum};

    // Head selection: payload first, then the summary of the same word
    assign head      = mem_reg[rd_ptr_reg];
    assign show_pay  = head.pay_v && !half_reg;
    assign out_item  = show_pay ? head.pay : head.sum;
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign fire      = out_valid && out_ready;
    assign pop       = fire && (!show_pay || !head.sum_v);

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        half_next   = fire ? !pop : half_reg;
        count_next  = count_reg;
        if (wr_en && !pop)
            count_next = count_reg + 1'b1;
        else if (!wr_en && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> room)
        else $error("write into a full queue");

    a_half_has_summary: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (out_valid && head.sum_v && head.pay_v))
        else $error("payload sent but no summary pending");

endmodule

`default_nettype wire

[design/channel_packet_deframer.sv]
// Top level of the channel packet deframer.
//
//  Channel  Dir  Beat contents
//  s_axis   in   tdata[31:0] word, tlast last_word
//  m_axis   out  tuser kind, tdata fields (see port), tlast end_mark
//
//  A word is taken in the cycle it is offered if the queue has room; header
//  capture, offset tracking and result building finish in that cycle and results
//  enter a two-entry queue. Sustained rate is one word per cycle while the output
//  is ready; a buffer's last word that also carries payload needs two output beats,
//  which can hold s_axis_tready low. Output stalls back up once both queue entries
//  are full. rst_n clears all packet state and empties the queue; no clearing pass.
`default_nettype none

module channel_packet_deframer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [31:0]                      s_axis_tdata,   // word
    input  wire logic                             s_axis_tlast,   // last_word
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // sample, chip, chan, sample_index, status, packets_seen, crossing_count, pad
    output logic [cpd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tuser,   // kind
    output logic                                  m_axis_tlast    // end_mark
);

    logic              accept;
    cpd_pkg::push_t    push;
    cpd_pkg::result_t  pay;
    cpd_pkg::result_t  sum;
    cpd_pkg::result_t  out_item;

    assign accept = s_axis_tvalid && s_axis_tready;

    cpd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (s_axis_tdata),
        .last_word (s_axis_tlast),
        .push      (push),
        .pay       (pay),
        .sum       (sum)
    );

    cpd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pay       (pay),
        .sum       (sum),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // Beat packing, first field lowest
    assign m_axis_tdata = {
        (cpd_pkg::OUT_TDATA_W - cpd_pkg::OUT_FIELDS_W)'(0),
        out_item.crossing_count,
        out_item.packets_seen,
        out_item.status,
        out_item.sample_index,
        out_item.chan,
        out_item.chip,
        out_item.sample
    };
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.end_mark;

endmodule

`default_nettype wire
